// ===== rtl/led_blink_note_sequencer_defines.svh =====
//------------------------------------------------------------------------------
// LED blink note sequencer assertion macros
// Shared macros that wrap concurrent assertions with the common clock and reset.
//------------------------------------------------------------------------------
`ifndef LED_BLINK_NOTE_SEQUENCER_DEFINES_SVH
`define LED_BLINK_NOTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBNS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbns assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbns assertion failed");

`endif

// ===== rtl/lbns_pkg.sv =====
//------------------------------------------------------------------------------
// LED blink note sequencer package
// Request and result types, command codes and reset constants.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbns_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_START    = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd32;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] channel;
        logic [6:0] on_frames;
        logic [6:0] off_frames;
        logic [7:0] repeat_count;
        logic       red_bit;
        logic       green_bit;
        logic       blue_bit;
        logic [7:0] start_note;
        logic [7:0] note_step;
    } in_item_t;

    typedef struct packed {
        logic       led_action;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       play_note;
        logic       stop_note;
        logic [7:0] tone_value;
        logic       last;
    } out_item_t;

    // Results caused by one request: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } evt_t;

endpackage

`default_nettype wire

// ===== rtl/led_blink_note_sequencer.sv =====
//------------------------------------------------------------------------------
// LED blink note sequencer
// Several blink channels sharing one RGB LED and one tone voice.
//------------------------------------------------------------------------------
// Throughput: one request per cycle while the result queue has room for two.
// Results are written into the registered result queue and leave on m_ from its head.
// The four-entry result queue sets the rate: s_ready drops at three or more held
// results, after back-to-back two-result requests or while m_ready is held low.
// Reset (aresetn low, synchronous) clears all channels, the LED owner and the
// queue, and sets brightness to 32.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_blink_note_sequencer_defines.svh"

module led_blink_note_sequencer #(
    parameter int CHANNELS = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Request channel.
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lbns_pkg::in_item_t  s_data,
    // Result channel.
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lbns_pkg::out_item_t      m_data,
    // Brightness register write port.
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data
);
    import lbns_pkg::*;

    // Brightness level used for every color component that is enabled.
    logic [7:0] brightness_reg;

    // Results of the accepted request, straight from the single-pass core.
    evt_t evt;

    // Result queue: four registered entries, up to two written per cycle,
    // one read per cycle at the head.
    out_item_t  queue_mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    logic       accept;
    logic       pop;
    logic [1:0] push_n;

    // A request may cause two results, so room for two is required.
    assign s_ready = (count_reg <= 3'd2);
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = queue_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign push_n  = accept ? evt.count : 2'd0;

    assign count_next = count_reg + {1'b0, push_n} - {2'b00, pop};

    lbns_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (accept),
        .in_item    (s_data),
        .brightness (brightness_reg),
        .evt        (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RESET;
        end else if (cfg_wr_en) begin
            brightness_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_mem[wr_ptr_reg] <= evt.first;
        end
        if (push_n == 2'd2) begin
            queue_mem[wr_ptr_reg + 2'd1] <= evt.second;
        end
    end

    // The queue never holds more than its four entries.
    `LBNS_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, count_reg <= 3'd4)

    // A result that is not the last of its request always has its partner
    // queued behind it, since both are written in the same cycle.
    `LBNS_ASSERT_NOW(a_pair_kept, aclk, aresetn, m_valid && !m_data.last, count_reg >= 3'd2)

    // Taking a result while nothing is written shrinks the queue by one.
    `LBNS_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && (push_n == 2'd0),
                      count_reg == $past(count_reg) - 3'd1)

endmodule

`default_nettype wire

// ===== rtl/lbns_core.sv =====
//------------------------------------------------------------------------------
// LED blink note sequencer core
// Per-channel pattern state and the single-pass request evaluation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbns_core #(
    parameter int CHANNELS = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire lbns_pkg::in_item_t in_item,
    input  wire logic [7:0]       brightness,
    output lbns_pkg::evt_t        evt
);
    import lbns_pkg::*;

    localparam int OWN_W = $clog2(CHANNELS);

    logic            lit_reg   [CHANNELS];
    logic            lit_next  [CHANNELS];
    logic [6:0]      fc_reg    [CHANNELS];
    logic [6:0]      fc_next   [CHANNELS];
    logic [7:0]      rep_reg   [CHANNELS];
    logic [7:0]      rep_next  [CHANNELS];
    logic [6:0]      on_reg    [CHANNELS];
    logic [6:0]      on_next   [CHANNELS];
    logic [6:0]      off_reg   [CHANNELS];
    logic [6:0]      off_next  [CHANNELS];
    logic [2:0]      color_reg [CHANNELS];
    logic [2:0]      color_next[CHANNELS];
    logic [7:0]      note_reg  [CHANNELS];
    logic [7:0]      note_next [CHANNELS];
    logic [7:0]      inc_reg   [CHANNELS];
    logic [7:0]      inc_next  [CHANNELS];
    logic [OWN_W-1:0] owner_reg;
    logic [OWN_W-1:0] owner_next;

    function automatic logic [6:0] dur(input logic [6:0] t);
        return (t == 7'd0) ? 7'd1 : t;
    endfunction

    // Queue a result; beyond two, later results merge into the second one.
    function automatic evt_t evt_push(input evt_t q, input out_item_t e);
        evt_t r;
        r = q;
        case (q.count)
            2'd0: begin
                r.first = e;
                r.count = 2'd1;
            end
            2'd1: begin
                r.second = e;
                r.count  = 2'd2;
            end
            default: begin
                r.second.led_action  = e.led_action;
                r.second.red_level   = e.red_level;
                r.second.green_level = e.green_level;
                r.second.blue_level  = e.blue_level;
                r.second.stop_note   = r.second.stop_note | e.stop_note;
                if (e.play_note) begin
                    r.second.play_note  = 1'b1;
                    r.second.tone_value = e.tone_value;
                end
            end
        endcase
        return r;
    endfunction

    always_comb begin
        out_item_t  e;
        evt_t       q;
        logic [3:0] ch_ext;
        logic       all_ch;
        logic       off;
        logic       hit;

        lit_next   = lit_reg;
        fc_next    = fc_reg;
        rep_next   = rep_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        color_next = color_reg;
        note_next  = note_reg;
        inc_next   = inc_reg;
        owner_next = owner_reg;
        q          = '0;
        e          = '0;
        ch_ext     = {2'b00, in_item.channel};
        all_ch     = (ch_ext == 4'(CHANNELS));
        off        = 1'b0;
        hit        = 1'b0;

        case (in_item.command)
            CMD_START: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (ch_ext == 4'(i)) begin
                        lit_next[i]   = 1'b0;
                        fc_next[i]    = 7'd0;
                        on_next[i]    = dur(in_item.on_frames);
                        off_next[i]   = dur(in_item.off_frames);
                        rep_next[i]   = in_item.repeat_count;
                        color_next[i] = {in_item.blue_bit, in_item.green_bit, in_item.red_bit};
                        note_next[i]  = in_item.start_note;
                        inc_next[i]   = in_item.note_step;
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (all_ch || (ch_ext == 4'(i))) begin
                        rep_next[i]   = 8'd0;
                        on_next[i]    = 7'd0;
                        off_next[i]   = 7'd0;
                        color_next[i] = 3'd0;
                        note_next[i]  = 8'd0;
                        inc_next[i]   = 8'd0;
                    end
                end
                off = all_ch || (ch_ext == 4'(owner_reg));
                if (off) begin
                    e            = '0;
                    e.led_action = 1'b1;
                    e.stop_note  = 1'b1;
                    q            = evt_push(q, e);
                end
            end
            CMD_TICK: begin
                // Channels are visited in order; ownership taken by an earlier
                // channel in this tick is seen by the later ones.
                for (int i = 0; i < CHANNELS; i++) begin
                    if (rep_next[i] != 8'd0) begin
                        // The frame count never passes the phase time, so the
                        // phase ends at a zero count or at the time itself.
                        if (lit_next[i]) begin
                            hit = (fc_next[i] == 7'd0) || (fc_next[i] == dur(on_next[i]));
                            if (hit) begin
                                lit_next[i] = 1'b0;
                                fc_next[i]  = 7'd0;
                                rep_next[i] = rep_next[i] - 8'd1;
                                if (owner_next == OWN_W'(i)) begin
                                    e            = '0;
                                    e.led_action = 1'b1;
                                    e.stop_note  = (note_next[i] != 8'd0);
                                    q            = evt_push(q, e);
                                end
                            end
                        end else begin
                            hit = (fc_next[i] == 7'd0) || (fc_next[i] == dur(off_next[i]));
                            if (hit) begin
                                lit_next[i]   = 1'b1;
                                fc_next[i]    = 7'd0;
                                e             = '0;
                                e.red_level   = color_next[i][0] ? brightness : 8'd0;
                                e.green_level = color_next[i][1] ? brightness : 8'd0;
                                e.blue_level  = color_next[i][2] ? brightness : 8'd0;
                                if (note_next[i] != 8'd0) begin
                                    e.play_note  = 1'b1;
                                    e.tone_value = note_next[i];
                                    note_next[i] = note_next[i] + inc_next[i];
                                end
                                owner_next = OWN_W'(i);
                                q          = evt_push(q, e);
                            end
                        end
                        fc_next[i] = fc_next[i] + 7'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (q.count == 2'd1) begin
            q.first.last = 1'b1;
        end else if (q.count == 2'd2) begin
            q.second.last = 1'b1;
        end
        evt = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                lit_reg[i]   <= 1'b0;
                fc_reg[i]    <= 7'd0;
                rep_reg[i]   <= 8'd0;
                on_reg[i]    <= 7'd0;
                off_reg[i]   <= 7'd0;
                color_reg[i] <= 3'd0;
                note_reg[i]  <= 8'd0;
                inc_reg[i]   <= 8'd0;
            end
            owner_reg <= '0;
        end else if (in_fire) begin
            lit_reg   <= lit_next;
            fc_reg    <= fc_next;
            rep_reg   <= rep_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            color_reg <= color_next;
            note_reg  <= note_next;
            inc_reg   <= inc_next;
            owner_reg <= owner_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
//------------------------------------------------------------------------------
// LED blink note sequencer testbench
// Drives blink starts, clears and frame ticks through the request channel with
// random idle gaps and result-side stalls. Expected results come from a
// behavioral model of every channel kept in the testbench. Each result is
// checked field by field against the oldest expected result. The run steps
// through several brightness settings, the extremes among them.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import lbns_pkg::*;

    localparam int CHANNELS      = 2;
    localparam int RESET_CYCLES  = 11;
    // Settle time after the last expected result; it covers a request still in
    // flight that produces nothing.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 200;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_wr_en;
    logic [7:0] cfg_wr_data;

    always #2 aclk = ~aclk;

    led_blink_note_sequencer #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    //--------------------------------------------------------------------------
    // Sequencer model state. Each channel holds its blink pattern, its phase
    // and its frame count; the LED owner is shared by all channels.
    //--------------------------------------------------------------------------
    logic       ch_lit       [CHANNELS];
    logic [6:0] ch_frames    [CHANNELS];
    logic [7:0] ch_repeats   [CHANNELS];
    logic [6:0] ch_on_len    [CHANNELS];
    logic [6:0] ch_off_len   [CHANNELS];
    logic [2:0] ch_color     [CHANNELS];
    logic [7:0] ch_note      [CHANNELS];
    logic [7:0] ch_note_step [CHANNELS];
    int unsigned led_holder;
    logic [7:0]  level_setting;

    // LED and tone events raised by one request, at most two of them.
    out_item_t step_events [2];
    int        step_count;

    // Requests waiting to be driven and results waiting to be seen.
    in_item_t  request_fifo     [$];
    out_item_t expected_results [$];

    int unsigned mismatches;
    int unsigned calm_cycles;

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            ch_lit[i]       = 1'b0;
            ch_frames[i]    = '0;
            ch_repeats[i]   = '0;
            ch_on_len[i]    = '0;
            ch_off_len[i]   = '0;
            ch_color[i]     = '0;
            ch_note[i]      = '0;
            ch_note_step[i] = '0;
        end
        led_holder    = 0;
        level_setting = BRIGHTNESS_RESET;
        mismatches    = 0;
        calm_cycles   = 0;
    end

    // A stored duration of zero lasts one frame.
    function automatic logic [6:0] frames_or_one(input logic [6:0] t);
        return (t == 7'd0) ? 7'd1 : t;
    endfunction

    // Queues an event for the current request. With two channels no more than
    // two events can occur, but a third one would fold into the second result,
    // taking the latest switch-on levels and the latest played note.
    task automatic post_event(input out_item_t ev);
        if (step_count < 2) begin
            step_events[step_count] = ev;
            step_count++;
        end else begin
            step_events[1].led_action  = ev.led_action;
            step_events[1].red_level   = ev.red_level;
            step_events[1].green_level = ev.green_level;
            step_events[1].blue_level  = ev.blue_level;
            step_events[1].stop_note   = step_events[1].stop_note | ev.stop_note;
            if (ev.play_note) begin
                step_events[1].play_note  = 1'b1;
                step_events[1].tone_value = ev.tone_value;
            end
        end
    endtask

    // Cancelling a pattern leaves the phase and the frame count as they were.
    task automatic cancel_pattern(input int unsigned ch);
        ch_repeats[ch]   = '0;
        ch_on_len[ch]    = '0;
        ch_off_len[ch]   = '0;
        ch_color[ch]     = '0;
        ch_note[ch]      = '0;
        ch_note_step[ch] = '0;
    endtask

    // Applies one accepted request to the model and queues its results.
    task automatic advance_sequencer(input in_item_t req);
        out_item_t   ev;
        int unsigned ch;
        logic        switch_off;
        int          k;
        step_count = 0;
        ch = 32'(req.channel);
        case (req.command)
            CMD_START: begin
                // A channel number past the last channel is ignored.
                if (ch < CHANNELS) begin
                    ch_lit[ch]       = 1'b0;
                    ch_frames[ch]    = '0;
                    ch_on_len[ch]    = frames_or_one(req.on_frames);
                    ch_off_len[ch]   = frames_or_one(req.off_frames);
                    ch_repeats[ch]   = req.repeat_count;
                    ch_color[ch]     = {req.blue_bit, req.green_bit, req.red_bit};
                    ch_note[ch]      = req.start_note;
                    ch_note_step[ch] = req.note_step;
                end
            end
            CMD_CLEAR: begin
                // The channel number one past the last means every channel;
                // anything beyond that is ignored.
                switch_off = 1'b0;
                if (ch == CHANNELS) begin
                    for (int i = 0; i < CHANNELS; i++)
                        cancel_pattern(i);
                    switch_off = 1'b1;
                end else if (ch < CHANNELS) begin
                    cancel_pattern(ch);
                    switch_off = (led_holder == ch);
                end
                if (switch_off) begin
                    ev            = '0;
                    ev.led_action = 1'b1;
                    ev.stop_note  = 1'b1;
                    post_event(ev);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (ch_repeats[i] == 8'd0)
                        continue;
                    if (ch_lit[i]) begin
                        // End of the on phase spends one blink; only the owner
                        // actually switches the LED off.
                        if (ch_frames[i] % frames_or_one(ch_on_len[i]) == 7'd0) begin
                            ch_lit[i]     = 1'b0;
                            ch_frames[i]  = '0;
                            ch_repeats[i] = ch_repeats[i] - 8'd1;
                            if (led_holder == i) begin
                                ev            = '0;
                                ev.led_action = 1'b1;
                                ev.stop_note  = (ch_note[i] != 8'd0);
                                post_event(ev);
                            end
                        end
                    end else if (ch_frames[i] % frames_or_one(ch_off_len[i]) == 7'd0) begin
                        // End of the off phase lights the LED in this channel's
                        // color and takes it over; a nonzero note plays and steps.
                        ch_lit[i]      = 1'b1;
                        ch_frames[i]   = '0;
                        ev             = '0;
                        ev.red_level   = ch_color[i][0] ? level_setting : 8'd0;
                        ev.green_level = ch_color[i][1] ? level_setting : 8'd0;
                        ev.blue_level  = ch_color[i][2] ? level_setting : 8'd0;
                        if (ch_note[i] != 8'd0) begin
                            ev.play_note  = 1'b1;
                            ev.tone_value = ch_note[i];
                            ch_note[i]    = ch_note[i] + ch_note_step[i];
                        end
                        led_holder = i;
                        post_event(ev);
                    end
                    ch_frames[i] = ch_frames[i] + 7'd1;
                end
            end
            default: begin
            end
        endcase
        for (k = 0; k < step_count; k++) begin
            ev      = step_events[k];
            ev.last = (k == step_count - 1);
            expected_results.push_back(ev);
        end
    endtask

    //--------------------------------------------------------------------------
    // Idle and stall lengths. Most gaps are short, a few are long, and now and
    // then a calm stretch lets both sides run at full rate.
    //--------------------------------------------------------------------------
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_cycles != 0)
            return 0;
        if (r < 65)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (calm_cycles != 0)
            calm_cycles <= calm_cycles - 1;
        else if ($urandom_range(0, 299) == 0)
            calm_cycles <= $urandom_range(100, 300);
    end

    //--------------------------------------------------------------------------
    // Request driver. The model is advanced at the edge where a request is
    // taken, so its results are queued before they can appear on m_.
    //--------------------------------------------------------------------------
    int unsigned send_pause;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            send_pause = 0;
        end else begin
            if (s_valid && s_ready)
                advance_sequencer(s_data);
            if (!s_valid || s_ready) begin
                if (send_pause != 0) begin
                    send_pause = send_pause - 1;
                    s_valid    <= 1'b0;
                end else if (request_fifo.size() != 0) begin
                    s_data     <= request_fifo.pop_front();
                    s_valid    <= 1'b1;
                    send_pause = pick_pause();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Result monitor.
    //--------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    int unsigned recv_pause;

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_pause = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, got %h", $time, m_data);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("led_action",  8'(want.led_action), 8'(m_data.led_action));
                    compare_field("red_level",   want.red_level,      m_data.red_level);
                    compare_field("green_level", want.green_level,    m_data.green_level);
                    compare_field("blue_level",  want.blue_level,     m_data.blue_level);
                    compare_field("play_note",   8'(want.play_note),  8'(m_data.play_note));
                    compare_field("stop_note",   8'(want.stop_note),  8'(m_data.stop_note));
                    compare_field("tone_value",  want.tone_value,     m_data.tone_value);
                    compare_field("last",        8'(want.last),       8'(m_data.last));
                end
            end
            if (recv_pause != 0) begin
                recv_pause = recv_pause - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                recv_pause = pick_pause();
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers.
    //--------------------------------------------------------------------------
    function automatic in_item_t make_request(
        input logic [1:0] command, input logic [1:0] channel,
        input logic [6:0] on_frames, input logic [6:0] off_frames,
        input logic [7:0] repeat_count, input logic [2:0] rgb,
        input logic [7:0] start_note, input logic [7:0] note_step);
        in_item_t req;
        req.command      = command;
        req.channel      = channel;
        req.on_frames    = on_frames;
        req.off_frames   = off_frames;
        req.repeat_count = repeat_count;
        req.red_bit      = rgb[0];
        req.green_bit    = rgb[1];
        req.blue_bit     = rgb[2];
        req.start_note   = start_note;
        req.note_step    = note_step;
        return req;
    endfunction

    // Short phases keep the channels blinking and overlapping; now and then a
    // full-range duration or repeat count shows up.
    function automatic logic [6:0] random_frames();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p < 15)
            return 7'($urandom_range(0, 3));
        if (p < 19)
            return 7'($urandom_range(4, 12));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] random_repeats();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p < 14)
            return 8'($urandom_range(1, 4));
        if (p < 17)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned r;
        r = $urandom_range(0, 99);
        req = make_request(CMD_TICK, 2'($urandom_range(0, 3)), random_frames(),
                           random_frames(), random_repeats(), 3'($urandom_range(0, 7)),
                           ($urandom_range(0, 19) < 6) ? 8'd0 : 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        if (r < 62) begin
            req.command = CMD_TICK;
        end else if (r < 82) begin
            req.command = CMD_START;
            req.channel = 2'($urandom_range(0, CHANNELS - 1));
        end else if (r < 92) begin
            req.command = CMD_CLEAR;
            req.channel = 2'($urandom_range(0, CHANNELS));
        end else begin
            // Requests that the block must ignore: the unused command code,
            // a start aimed past the last channel, or a clear past the all value.
            case ($urandom_range(0, 2))
                0: req.command = CMD_RESERVED;
                1: begin
                    req.command = CMD_START;
                    req.channel = 2'($urandom_range(CHANNELS, 3));
                end
                default: begin
                    req.command = CMD_CLEAR;
                    req.channel = 2'd3;
                end
            endcase
        end
        return req;
    endfunction

    // Waits until every request is taken and every result has come, then
    // lets the block settle.
    task automatic wait_for_idle();
        @(negedge aclk);
        while (request_fifo.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_brightness(input logic [7:0] level);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= level;
        level_setting = level;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    //--------------------------------------------------------------------------
    // Test sequence.
    //--------------------------------------------------------------------------
    initial begin
        logic [7:0]  level_plan [4];
        in_item_t    req;
        int unsigned counted;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, at the reset brightness.
        // Nothing is active, so a tick is silent; channel 0 owns the LED after
        // reset, so clearing it switches off while clearing channel 1 does not.
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd1, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Zero durations act as one frame; the note wraps past 255. Channel 1
        // gets the longest durations and the most repeats. Both light on the
        // first tick, then channel 0 blinks once more on its own.
        request_fifo.push_back(make_request(CMD_START, 2'd0, 7'd0, 7'd0, 8'd2, 3'd7,
                                            8'd255, 8'd255));
        request_fifo.push_back(make_request(CMD_START, 2'd1, 7'd127, 7'd127, 8'd255, 3'd0,
                                            8'd0, 8'd0));
        repeat (4)
            request_fifo.push_back(make_request(CMD_TICK, 2'd3, 7'd0, 7'd0, 8'd0, 3'd0,
                                                8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd1, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Two channels lighting on one tick, then the owner going dark while
        // the other channel also finishes without touching the LED.
        request_fifo.push_back(make_request(CMD_START, 2'd0, 7'd1, 7'd2, 8'd1, 3'd1, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_START, 2'd1, 7'd1, 7'd1, 8'd1, 3'd4, 8'd1, 8'd2));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // The owner switching off and the other channel switching on in the
        // same tick.
        request_fifo.push_back(make_request(CMD_START, 2'd0, 7'd1, 7'd1, 8'd1, 3'd3, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_START, 2'd1, 7'd1, 7'd1, 8'd1, 3'd6, 8'd5, 8'd0));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Requests the block ignores: starts past the last channel, a clear
        // past the all value, and the unused command with every field at max.
        request_fifo.push_back(make_request(CMD_START, 2'd2, 7'd1, 7'd1, 8'd1, 3'd7, 8'd9, 8'd1));
        request_fifo.push_back(make_request(CMD_START, 2'd3, 7'd1, 7'd1, 8'd1, 3'd7, 8'd9, 8'd1));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd3, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_RESERVED, 2'd3, 7'd127, 7'd127, 8'd255, 3'd7,
                                            8'd255, 8'd255));
        // Clearing all switches off; clearing the owner switches off too.
        request_fifo.push_back(make_request(CMD_START, 2'd1, 7'd2, 7'd3, 8'd3, 3'd2, 8'd10, 8'd0));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd2, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_START, 2'd0, 7'd127, 7'd127, 8'd255, 3'd7,
                                            8'd255, 8'd255));
        request_fifo.push_back(make_request(CMD_TICK,  2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        request_fifo.push_back(make_request(CMD_CLEAR, 2'd0, 7'd0, 7'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        wait_for_idle();

        // Random part, one phase per brightness setting, extremes included.
        level_plan[0] = 8'd255;
        level_plan[1] = 8'd0;
        level_plan[2] = 8'($urandom_range(2, 254));
        level_plan[3] = 8'd1;
        for (int p = 0; p < 4; p++) begin
            write_brightness(level_plan[p]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req = random_request();
                request_fifo.push_back(req);
                // Ignored requests do not count toward the phase length.
                if (!(req.command == CMD_RESERVED ||
                      (req.command == CMD_START && req.channel >= CHANNELS) ||
                      (req.command == CMD_CLEAR && req.channel > CHANNELS)))
                    counted++;
            end
            wait_for_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lbns_pkg.sv
rtl/lbns_core.sv
rtl/led_blink_note_sequencer.sv
test/testbench.sv
